@@ sv/qrsdp_pkg.sv @@
// qrsdp_pkg: shared types, constants and the alphanumeric lookup for the
// qr segment data packer. No dependencies; every other file uses it.
`timescale 1ns / 1ps

package qrsdp_pkg;

  // encode_mode codes
  localparam logic [1:0] MODE_NUMERIC = 2'd0;
  localparam logic [1:0] MODE_ALNUM   = 2'd1;
  localparam logic [1:0] MODE_BYTE    = 2'd2;
  localparam logic [1:0] MODE_RESET   = MODE_BYTE;

  // configuration register indexes
  localparam logic REG_ENCODE_MODE = 1'b0;

  localparam int CHAR_W  = 8;
  localparam int ACC_W   = 11;
  localparam int POS_W   = 2;
  localparam int BITS_W  = 4;
  localparam int COUNT_W = 16;
  localparam int KEY_W   = 6;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [KEY_W-1:0]   ALNUM_RADIX = 6'd45;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

  // chunk lengths
  localparam logic [BITS_W-1:0] BITS_NUM_ONE   = 4'd4;
  localparam logic [BITS_W-1:0] BITS_ALNUM_ONE = 4'd6;
  localparam logic [BITS_W-1:0] BITS_NUM_TWO   = 4'd7;
  localparam logic [BITS_W-1:0] BITS_BYTE      = 4'd8;
  localparam logic [BITS_W-1:0] BITS_NUM_THREE = 4'd10;
  localparam logic [BITS_W-1:0] BITS_ALNUM_TWO = 4'd11;

  typedef struct packed {
    logic [ACC_W-1:0]   group_acc;
    logic [POS_W-1:0]   group_pos;
    logic [COUNT_W-1:0] char_counter;
    logic               bad_flag;
  } seg_state_t;

  typedef struct packed {
    logic [ACC_W-1:0]   chunk_value;
    logic [BITS_W-1:0]  chunk_bits;
    logic               segment_end;
    logic [COUNT_W-1:0] char_total;
    logic               bad_char_seen;
  } chunk_t;

  // index in the 45-symbol set, ALNUM_RADIX when the byte is not in it
  function automatic logic [KEY_W-1:0] alnum_key(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h37;
    end else begin
      case (c)
        8'h20:   d = 8'd36;
        8'h24:   d = 8'd37;
        8'h25:   d = 8'd38;
        8'h2A:   d = 8'd39;
        8'h2B:   d = 8'd40;
        8'h2D:   d = 8'd41;
        8'h2E:   d = 8'd42;
        8'h2F:   d = 8'd43;
        8'h3A:   d = 8'd44;
        default: d = 8'd45;
      endcase
    end
    return d[KEY_W-1:0];
  endfunction

endpackage

@@ sv/qrsdp_in_if.sv @@
// qrsdp_in_if: character input channel, valid/ready with payload.
// Depends on qrsdp_pkg for field widths.
`timescale 1ns / 1ps

interface qrsdp_in_if;
  logic                          valid;
  logic                          ready;
  logic [qrsdp_pkg::CHAR_W-1:0]  char_in;
  logic                          is_final;

  modport source (output valid, output char_in, output is_final, input ready);
  modport sink   (input valid, input char_in, input is_final, output ready);
endinterface

@@ sv/qrsdp_out_if.sv @@
// qrsdp_out_if: packed chunk output channel, valid/ready with payload.
// Depends on qrsdp_pkg for field widths.
`timescale 1ns / 1ps

interface qrsdp_out_if;
  logic                           valid;
  logic                           ready;
  logic [qrsdp_pkg::ACC_W-1:0]    chunk_value;
  logic [qrsdp_pkg::BITS_W-1:0]   chunk_bits;
  logic                           segment_end;
  logic [qrsdp_pkg::COUNT_W-1:0]  char_total;
  logic                           bad_char_seen;

  modport source (output valid, output chunk_value, output chunk_bits,
                  output segment_end, output char_total, output bad_char_seen,
                  input ready);
  modport sink   (input valid, input chunk_value, input chunk_bits,
                  input segment_end, input char_total, input bad_char_seen,
                  output ready);
endinterface

@@ sv/qr_segment_data_packer.sv @@
// qr_segment_data_packer: top level, input register, packing step, result
// register and apb configuration. Depends on qrsdp_pkg, qrsdp_in_if,
// qrsdp_out_if, qrsdp_apb_regs and qrsdp_step.
`timescale 1ns / 1ps
//
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      char_in[7:0], is_final
//  out_ch    out  valid/ready      chunk_value[10:0], chunk_bits[3:0], segment_end,
//                                  char_total[15:0], bad_char_seen
//  apb       in   psel/penable     paddr[2:0], pwdata[31:0] -> prdata[31:0]
//
//  one character per cycle sustained while the output is not stalled; a chunk
//  goes from its input transaction through the input register, then the
//  packing step into the result register, where it shows valid
//  the segment state loop (accumulator, group position, count, flag) closes through the packing step
//  rst is synchronous: drops both valid stages, clears the segment state, mode to byte
//  a stalled output holds its chunk; the input register still moves into the
//  result register when the result register is being drained in the same cycle

module qr_segment_data_packer (
  input  logic                          clk,
  input  logic                          rst,
  qrsdp_in_if.sink                      in_ch,
  qrsdp_out_if.source                   out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qrsdp_pkg::APB_AW-1:0]  paddr,
  input  logic [qrsdp_pkg::APB_DW-1:0]  pwdata,
  output logic [qrsdp_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);

  logic [1:0] encode_mode;

  // input register
  logic                         in_valid;
  logic [qrsdp_pkg::CHAR_W-1:0] in_char;
  logic                         in_final;

  // segment state carried between characters
  qrsdp_pkg::seg_state_t seg_state;
  qrsdp_pkg::seg_state_t seg_state_next;

  // result register
  logic              res_valid;
  qrsdp_pkg::chunk_t res_chunk;

  logic              step_emit;
  qrsdp_pkg::chunk_t step_chunk;
  logic              advance;
  logic              in_take;

  qrsdp_apb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .encode_mode (encode_mode)
  );

  qrsdp_step u_step (
    .encode_mode (encode_mode),
    .char_in     (in_char),
    .is_final    (in_final),
    .cur         (seg_state),
    .nxt         (seg_state_next),
    .emit        (step_emit),
    .chunk       (step_chunk)
  );

  // the held character moves on when the result register is free or draining
  assign advance     = in_valid & (~res_valid | out_ch.ready);
  assign in_ch.ready = ~in_valid | advance;
  assign in_take     = in_ch.valid & in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_char  <= in_ch.char_in;
      in_final <= in_ch.is_final;
    end
  end

  // state updates once per character, whether or not a chunk comes out
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_state <= '0;
    end else if (advance) begin
      seg_state <= seg_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && step_emit) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_emit) begin
      res_chunk <= step_chunk;
    end
  end

  assign out_ch.valid         = res_valid;
  assign out_ch.chunk_value   = res_chunk.chunk_value;
  assign out_ch.chunk_bits    = res_chunk.chunk_bits;
  assign out_ch.segment_end   = res_chunk.segment_end;
  assign out_ch.char_total    = res_chunk.char_total;
  assign out_ch.bad_char_seen = res_chunk.bad_char_seen;

endmodule

@@ sv/qrsdp_apb_regs.sv @@
// qrsdp_apb_regs: apb register file holding encode_mode.
// Depends on qrsdp_pkg.
`timescale 1ns / 1ps

module qrsdp_apb_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qrsdp_pkg::APB_AW-1:0]   paddr,
  input  logic [qrsdp_pkg::APB_DW-1:0]   pwdata,
  output logic [qrsdp_pkg::APB_DW-1:0]   prdata,
  output logic                           pready,
  output logic [1:0]                     encode_mode
);

  logic reg_index;
  logic wr_en;

  assign reg_index = paddr[qrsdp_pkg::APB_AW-1];
  assign pready    = 1'b1;
  assign wr_en     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      encode_mode <= qrsdp_pkg::MODE_RESET;
    end else if (wr_en && reg_index == qrsdp_pkg::REG_ENCODE_MODE) begin
      encode_mode <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == qrsdp_pkg::REG_ENCODE_MODE) begin
      prdata = {{(qrsdp_pkg::APB_DW-2){1'b0}}, encode_mode};
    end
  end

endmodule

@@ sv/qrsdp_step.sv @@
// qrsdp_step: combinational packing step for one character, giving the
// next segment state and the chunk it emits. Depends on qrsdp_pkg.
`timescale 1ns / 1ps

module qrsdp_step (
  input  logic [1:0]                     encode_mode,
  input  logic [qrsdp_pkg::CHAR_W-1:0]   char_in,
  input  logic                           is_final,
  input  qrsdp_pkg::seg_state_t          cur,
  output qrsdp_pkg::seg_state_t          nxt,
  output logic                           emit,
  output qrsdp_pkg::chunk_t              chunk
);

  logic [qrsdp_pkg::COUNT_W-1:0] count_inc;
  logic [qrsdp_pkg::POS_W-1:0]   pos_inc;
  logic                          is_digit;
  logic [3:0]                    digit;
  logic [qrsdp_pkg::CHAR_W-1:0]  digit_full;
  logic [qrsdp_pkg::KEY_W-1:0]   key_raw;
  logic [qrsdp_pkg::KEY_W-1:0]   key;
  logic [14:0]                   num_acc;
  logic [16:0]                   alnum_acc;
  logic [qrsdp_pkg::ACC_W-1:0]   acc_upd;
  logic                          bad_upd;
  logic [qrsdp_pkg::ACC_W-1:0]   value;
  logic [qrsdp_pkg::BITS_W-1:0]  bits;

  assign count_inc  = (cur.char_counter != qrsdp_pkg::COUNT_MAX) ?
                      cur.char_counter + 16'd1 : cur.char_counter;
  assign pos_inc    = cur.group_pos + 2'd1;
  assign is_digit   = (char_in >= 8'h30) && (char_in <= 8'h39);
  assign digit_full = char_in - 8'h30;
  assign digit      = is_digit ? digit_full[3:0] : 4'd0;
  assign key_raw    = qrsdp_pkg::alnum_key(char_in);
  assign key        = (key_raw == qrsdp_pkg::ALNUM_RADIX) ? 6'd0 : key_raw;
  assign num_acc    = {4'd0, cur.group_acc} * 15'd10 + {11'd0, digit};
  assign alnum_acc  = {6'd0, cur.group_acc} * 17'd45 + {11'd0, key};

  always_comb begin
    emit    = 1'b0;
    value   = '0;
    bits    = '0;
    acc_upd = cur.group_acc;
    bad_upd = cur.bad_flag;
    case (encode_mode)
      qrsdp_pkg::MODE_NUMERIC: begin
        acc_upd = num_acc[qrsdp_pkg::ACC_W-1:0];
        bad_upd = cur.bad_flag | ~is_digit;
        value   = acc_upd;
        if (pos_inc == 2'd3) begin
          emit = 1'b1;
          bits = qrsdp_pkg::BITS_NUM_THREE;
        end else if (is_final) begin
          emit = 1'b1;
          bits = (pos_inc == 2'd2) ? qrsdp_pkg::BITS_NUM_TWO : qrsdp_pkg::BITS_NUM_ONE;
        end
      end
      qrsdp_pkg::MODE_ALNUM: begin
        acc_upd = alnum_acc[qrsdp_pkg::ACC_W-1:0];
        bad_upd = cur.bad_flag | (key_raw == qrsdp_pkg::ALNUM_RADIX);
        value   = acc_upd;
        // a pair (or longer group left from numeric) closes here
        if (pos_inc[1]) begin
          emit = 1'b1;
          bits = qrsdp_pkg::BITS_ALNUM_TWO;
        end else if (is_final) begin
          emit = 1'b1;
          bits = qrsdp_pkg::BITS_ALNUM_ONE;
        end
      end
      default: begin
        // byte mode and the unused code
        emit  = 1'b1;
        value = {3'd0, char_in};
        bits  = qrsdp_pkg::BITS_BYTE;
      end
    endcase
  end

  always_comb begin
    nxt.group_acc    = acc_upd;
    nxt.group_pos    = pos_inc;
    nxt.char_counter = count_inc;
    nxt.bad_flag     = bad_upd;
    if (emit || is_final) begin
      nxt.group_acc = '0;
      nxt.group_pos = '0;
    end
    if (is_final) begin
      nxt.char_counter = '0;
      nxt.bad_flag     = 1'b0;
    end
  end

  assign chunk.chunk_value   = value;
  assign chunk.chunk_bits    = bits;
  assign chunk.segment_end   = is_final;
  assign chunk.char_total    = is_final ? count_inc : '0;
  assign chunk.bad_char_seen = bad_upd;

endmodule
